@@ rtl/nrpd_pkg.sv @@
// Shared types and constants for the nibble RLE to planar decoder.
// Depends on nothing; every other file imports it.
package nrpd_pkg;

    // Fixed field widths
    localparam int ROW_WIDTH_W     = 10;
    localparam int GROUP_INDEX_W   = 7;
    localparam int RUN_W           = 9;    // longest run is 0xFF + 16

    // Defaults and constants
    localparam int DEF_MAX_ROW_PIXELS = 640;
    localparam int RESET_ROW_WIDTH    = 640;
    localparam int LONG_RUN_BIAS      = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch a new code word
        logic dec;        // decode the current nibble
        logic run_step;   // place one chunk of the current run
        logic next_nib;   // move on to the high nibble
        logic flush;      // push the held group out as last of burst
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic hold_valid; // a finished group waits in the hold register
        logic hi_nib;     // high nibble is current
        logic dec_place;  // current nibble is a literal pixel
        logic dec_run;    // current nibble starts a run
        logic dec_end;    // a literal pixel would close the row
        logic run_end;    // this run chunk closes the row
        logic run_last;   // this run chunk finishes the run
    } sts_t;

endpackage

@@ rtl/nrpd_ctrl.sv @@
// Controller state machine of the nibble RLE to planar decoder.
// Depends on nrpd_pkg; drives commands to nrpd_datapath.
module nrpd_ctrl
    import nrpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       can_emit;

    // A step may produce a group only if the hold register can be emptied
    assign can_emit = !sts.hold_valid || sts.out_free;
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (can_emit)
                begin
                    cmd.dec = 1'b1;
                    if (sts.dec_place && sts.dec_end)
                        state_next = ST_FLUSH;
                    else if (sts.dec_run)
                        state_next = ST_RUN;
                    else if (sts.hi_nib)
                        state_next = ST_FLUSH;
                    else
                        cmd.next_nib = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (can_emit)
                begin
                    cmd.run_step = 1'b1;
                    if (sts.run_end)
                        state_next = ST_FLUSH;
                    else if (sts.run_last)
                    begin
                        if (sts.hi_nib)
                            state_next = ST_FLUSH;
                        else
                        begin
                            cmd.next_nib = 1'b1;
                            state_next   = ST_DECODE;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.hold_valid)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/nrpd_datapath.sv @@
// Datapath of the nibble RLE to planar decoder: decode state, pixel
// placement into bitplanes, hold and output registers. Depends on nrpd_pkg.
module nrpd_datapath
    import nrpd_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [7:0]               code_byte,
    input  logic                     cfg_we,
    input  logic [ROW_WIDTH_W-1:0]   row_width,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [GROUP_INDEX_W-1:0] group_index,
    output logic [7:0]               plane_zero,
    output logic [7:0]               plane_one,
    output logic [7:0]               plane_two,
    output logic [7:0]               plane_three,
    output logic                     row_end,
    output logic                     last_of_burst
);

    localparam int PW     = $clog2(MAX_ROW_PIXELS + 1);
    localparam int NW     = (PW > RUN_W) ? PW : RUN_W;
    localparam int EW_RST = (RESET_ROW_WIDTH > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS
                                                               : RESET_ROW_WIDTH;

    localparam logic [1:0] MODE_LIT = 2'd0;
    localparam logic [1:0] MODE_CNT = 2'd1;
    localparam logic [1:0] MODE_LLO = 2'd2;
    localparam logic [1:0] MODE_LHI = 2'd3;

    // Control and decode state
    logic                     hi_reg, hi_next;
    logic [1:0]               mode_reg, mode_next;
    logic [3:0]               prev_reg, prev_next;
    logic [3:0]               llo_reg, llo_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [3:0][7:0]          planes_reg, planes_next;
    logic [2:0]               fill_reg, fill_next;
    logic [PW-1:0]            ew_reg, ew_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic                     out_valid_reg, out_valid_next;

    // Payload registers
    logic [7:0]               byte_reg, byte_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic [3:0][7:0]          hold_planes_reg, hold_planes_next;
    logic [GROUP_INDEX_W-1:0] hold_idx_reg, hold_idx_next;
    logic                     hold_end_reg, hold_end_next;
    logic [3:0][7:0]          out_planes_reg, out_planes_next;
    logic [GROUP_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic                     out_end_reg, out_end_next;
    logic                     out_last_reg, out_last_next;

    // Step signals
    logic [3:0]               nib;
    logic                     lit_place;
    logic                     run_start;
    logic [PW-1:0]            left;
    logic [3:0]               room;
    logic [NW-1:0]            min_a;
    logic [NW-1:0]            min_b;
    logic [3:0]               n_run;
    logic [PW:0]              pos_lit;
    logic [PW:0]              pos_run;
    logic                     end_lit;
    logic                     end_run;
    logic                     place;
    logic [3:0]               n_sel;
    logic [3:0]               color;
    logic [PW:0]              pos_sum;
    logic                     row_done;
    logic [3:0]               fill_sum;
    logic [7:0]               mask_hi;
    logic [7:0]               mask_lo;
    logic [7:0]               mask;
    logic [3:0][7:0]          planes_put;
    logic                     emit;
    logic [31:0]              idx_wide;
    logic [31:0]              width_wide;

    // Current nibble and what it means in the current mode
    assign nib       = hi_reg ? byte_reg[7:4] : byte_reg[3:0];
    assign lit_place = (mode_reg == MODE_LIT) && (nib != prev_reg);
    assign run_start = ((mode_reg == MODE_CNT) && (nib != 4'd0)) || (mode_reg == MODE_LHI);

    // Run chunk: limited by run left, room in the group and pixels left in row
    assign left  = (pos_reg < ew_reg) ? (ew_reg - pos_reg) : PW'(1);
    assign room  = 4'd8 - {1'b0, fill_reg};
    assign min_a = (NW'(run_reg) < NW'(room)) ? NW'(run_reg) : NW'(room);
    assign min_b = (min_a < NW'(left)) ? min_a : NW'(left);
    assign n_run = min_b[3:0];

    // Row end checks for a single pixel and for a run chunk
    assign pos_lit = {1'b0, pos_reg} + (PW+1)'(1);
    assign pos_run = {1'b0, pos_reg} + (PW+1)'(n_run);
    assign end_lit = (pos_lit >= {1'b0, ew_reg});
    assign end_run = (pos_run >= {1'b0, ew_reg});

    // Selected placement
    assign place    = cmd.run_step || (cmd.dec && lit_place);
    assign n_sel    = cmd.run_step ? n_run : 4'd1;
    assign color    = cmd.run_step ? prev_reg : nib;
    assign pos_sum  = cmd.run_step ? pos_run : pos_lit;
    assign row_done = cmd.run_step ? end_run : end_lit;

    // Bit mask covering the placed pixels, first pixel in the MSB
    assign fill_sum = {1'b0, fill_reg} + n_sel;
    assign mask_hi  = 8'hFF >> fill_reg;
    assign mask_lo  = fill_sum[3] ? 8'h00 : (8'hFF >> fill_sum[2:0]);
    assign mask     = mask_hi & ~mask_lo;
    assign emit     = fill_sum[3] || row_done;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            planes_put[p] = planes_reg[p] | (color[p] ? mask : 8'h00);
        end
    end

    assign idx_wide   = 32'(pos_reg) >> 3;
    assign width_wide = 32'(row_width);

    // Status
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.hi_nib     = hi_reg;
    assign sts.dec_place  = lit_place;
    assign sts.dec_run    = run_start;
    assign sts.dec_end    = end_lit;
    assign sts.run_end    = end_run;
    assign sts.run_last   = (run_reg == RUN_W'(n_run));

    // Next state
    always_comb
    begin
        hi_next          = hi_reg;
        mode_next        = mode_reg;
        prev_next        = prev_reg;
        llo_next         = llo_reg;
        pos_next         = pos_reg;
        planes_next      = planes_reg;
        fill_next        = fill_reg;
        ew_next          = ew_reg;
        hold_valid_next  = hold_valid_reg;
        out_valid_next   = out_valid_reg;
        byte_next        = byte_reg;
        run_next         = run_reg;
        hold_planes_next = hold_planes_reg;
        hold_idx_next    = hold_idx_reg;
        hold_end_next    = hold_end_reg;
        out_planes_next  = out_planes_reg;
        out_idx_next     = out_idx_reg;
        out_end_next     = out_end_reg;
        out_last_next    = out_last_reg;

        // Row width register, stored already clamped
        if (cfg_we)
        begin
            if (width_wide == 32'd0)
                ew_next = PW'(1);
            else if (width_wide > 32'(MAX_ROW_PIXELS))
                ew_next = PW'(MAX_ROW_PIXELS);
            else
                ew_next = PW'(width_wide);
        end

        // New code word
        if (cmd.load)
        begin
            byte_next = code_byte;
            hi_next   = 1'b0;
        end
        if (cmd.next_nib)
            hi_next = 1'b1;

        // Nibble decode without placement
        if (cmd.dec && !lit_place)
        begin
            case (mode_reg)
                MODE_LIT:
                begin
                    mode_next = MODE_CNT;
                end
                MODE_CNT:
                begin
                    if (nib == 4'd0)
                        mode_next = MODE_LLO;
                    else
                    begin
                        run_next  = RUN_W'(nib);
                        mode_next = MODE_LIT;
                    end
                end
                MODE_LLO:
                begin
                    llo_next  = nib;
                    mode_next = MODE_LHI;
                end
                default:
                begin
                    run_next  = RUN_W'({nib, llo_reg}) + RUN_W'(LONG_RUN_BIAS);
                    mode_next = MODE_LIT;
                end
            endcase
        end

        // Output register drains
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // Pixel placement
        if (place)
        begin
            if (cmd.dec)
                prev_next = nib;
            run_next    = run_reg - RUN_W'(n_sel);
            planes_next = planes_put;
            fill_next   = fill_sum[2:0];
            pos_next    = pos_sum[PW-1:0];
            if (emit)
            begin
                // Older held group goes out, not last of its burst
                if (hold_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_planes_next = hold_planes_reg;
                    out_idx_next    = hold_idx_reg;
                    out_end_next    = hold_end_reg;
                    out_last_next   = 1'b0;
                end
                hold_valid_next  = 1'b1;
                hold_planes_next = planes_put;
                hold_idx_next    = GROUP_INDEX_W'(idx_wide);
                hold_end_next    = row_done;
                planes_next      = '0;
                fill_next        = 3'd0;
            end
            if (row_done)
            begin
                pos_next  = '0;
                prev_next = 4'd0;
                mode_next = MODE_LIT;
                llo_next  = 4'd0;
            end
        end

        // End of word: the held group is the last one
        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_planes_next = hold_planes_reg;
            out_idx_next    = hold_idx_reg;
            out_end_next    = hold_end_reg;
            out_last_next   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    // Control and decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg         <= 1'b0;
            mode_reg       <= MODE_LIT;
            prev_reg       <= 4'd0;
            llo_reg        <= 4'd0;
            pos_reg        <= '0;
            planes_reg     <= '0;
            fill_reg       <= 3'd0;
            ew_reg         <= PW'(EW_RST);
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hi_reg         <= hi_next;
            mode_reg       <= mode_next;
            prev_reg       <= prev_next;
            llo_reg        <= llo_next;
            pos_reg        <= pos_next;
            planes_reg     <= planes_next;
            fill_reg       <= fill_next;
            ew_reg         <= ew_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        run_reg         <= run_next;
        hold_planes_reg <= hold_planes_next;
        hold_idx_reg    <= hold_idx_next;
        hold_end_reg    <= hold_end_next;
        out_planes_reg  <= out_planes_next;
        out_idx_reg     <= out_idx_next;
        out_end_reg     <= out_end_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign group_index   = out_idx_reg;
    assign plane_zero    = out_planes_reg[0];
    assign plane_one     = out_planes_reg[1];
    assign plane_two     = out_planes_reg[2];
    assign plane_three   = out_planes_reg[3];
    assign row_end       = out_end_reg;
    assign last_of_burst = out_last_reg;

endmodule

@@ rtl/nibble_rle_to_planar_decoder.sv @@
// Nibble RLE to planar decoder, top level.
// Depends on nrpd_pkg, nrpd_ctrl and nrpd_datapath.
//
// Input channel (in_valid / in_stall / code_byte): one encoded word per
// handshake, low nibble decoded first. Output channel (out_valid /
// out_stall / group fields): one word per 8-pixel group, four bitplane
// bytes, first pixel in the MSB; a short group at row end is zero padded
// and flagged by row_end; last_of_burst marks the final group of a word.
// Config channel (cfg_valid / cfg_ready / row_width): write only while
// idle; cfg_ready is always high. Width 0 acts as 1, widths above
// MAX_ROW_PIXELS act as MAX_ROW_PIXELS.
// A word of two plain nibbles passes accept, decode of each nibble and
// release; a row end on the low nibble skips the high nibble. A run
// is placed chunk by chunk (a chunk ends at a group boundary, row end or
// run end; up to 8 pixels a cycle unless stalled). A finished group waits
// in a hold register until the next group is done or the word ends; the
// last group of a word moves out in the release step.
// Reset: row width returns to 640 (clamped), decoder state to empty row.
// A stalled output holds its word; decoding pauses while a finished
// group cannot move to the output register.
module nibble_rle_to_planar_decoder
    import nrpd_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = DEF_MAX_ROW_PIXELS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               code_byte,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ROW_WIDTH_W-1:0]   row_width,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [GROUP_INDEX_W-1:0] group_index,
    output logic [7:0]               plane_zero,
    output logic [7:0]               plane_one,
    output logic [7:0]               plane_two,
    output logic [7:0]               plane_three,
    output logic                     row_end,
    output logic                     last_of_burst
);

    cmd_t cmd;
    sts_t sts;

    // Config writes must only be issued while idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    nrpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    nrpd_datapath #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .code_byte     (code_byte),
        .cfg_we        (cfg_valid && cfg_ready),
        .row_width     (row_width),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .group_index   (group_index),
        .plane_zero    (plane_zero),
        .plane_one     (plane_one),
        .plane_two     (plane_two),
        .plane_three   (plane_three),
        .row_end       (row_end),
        .last_of_burst (last_of_burst)
    );

endmodule

@@ rtl/nrpd_checker.sv @@
// Port-level checks for the nibble RLE to planar decoder, bound to the top.
// Depends on nrpd_pkg for field widths.
module nrpd_checker
    import nrpd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [GROUP_INDEX_W-1:0] group_index,
    input logic [7:0]               plane_zero,
    input logic                     row_end,
    input logic                     last_of_burst
);

    // One word at a time: after an accepted word the input stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // When idle, any pending output word must close its burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && out_valid) |-> last_of_burst)
        else $error("idle with an unfinished burst on the output");

    // A stalled output word stays and holds group_index, plane_zero, row_end and last_of_burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(group_index) && $stable(plane_zero)
             && $stable(row_end) && $stable(last_of_burst)))
        else $error("stalled output word changed");

endmodule

bind nibble_rle_to_planar_decoder nrpd_checker u_nrpd_checker (.*);

@@ test/nibble_rle_to_planar_decoder_tb.sv @@
// Self-checking testbench for nibble_rle_to_planar_decoder: RLE nibble streams in, bitplane
// groups out, each checked against an in-bench decoder model at the word level.
// Depends on nrpd_pkg and the decoder RTL only.
module nibble_rle_to_planar_decoder_tb
    import nrpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 20;

    typedef enum logic [1:0] {
        MODE_LITERAL,
        MODE_COUNT,
        MODE_LONG_LO,
        MODE_LONG_HI
    } nibble_mode_t;

    typedef struct packed {
        logic [GROUP_INDEX_W-1:0] group_index;
        logic [7:0]               plane_zero;
        logic [7:0]               plane_one;
        logic [7:0]               plane_two;
        logic [7:0]               plane_three;
        logic                     row_end;
        logic                     last_of_burst;
    } group_word_t;

    // DUT signals
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [7:0]               code_byte = '0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [ROW_WIDTH_W-1:0]   row_width = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [GROUP_INDEX_W-1:0] group_index;
    logic [7:0]               plane_zero;
    logic [7:0]               plane_one;
    logic [7:0]               plane_two;
    logic [7:0]               plane_three;
    logic                     row_end;
    logic                     last_of_burst;

    // Decoder model state
    logic [ROW_WIDTH_W-1:0] width_setting = ROW_WIDTH_W'(RESET_ROW_WIDTH);
    nibble_mode_t           dec_mode = MODE_LITERAL;
    logic [3:0]             prev_pixel = '0;
    logic [3:0]             long_lo = '0;
    int unsigned            row_pos = 0;
    logic [31:0]            group_planes = '0;
    int unsigned            group_fill = 0;

    // Stimulus and scoreboard
    logic [7:0]  pending_bytes[$];
    group_word_t expected_groups[$];
    logic [3:0]  gen_nibbles[$];
    logic [3:0]  guess_pixel = '0;
    int unsigned errors = 0;
    int unsigned bytes_taken = 0;
    int unsigned cycle_count = 0;
    bit          byte_taken = 1'b0;

    // Sender burst/gap state
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    // Receiver stall pattern state
    int unsigned sink_mode = 0;
    int unsigned seg_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    nibble_rle_to_planar_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_byte     (code_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .row_width     (row_width),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .group_index   (group_index),
        .plane_zero    (plane_zero),
        .plane_one     (plane_one),
        .plane_two     (plane_two),
        .plane_three   (plane_three),
        .row_end       (row_end),
        .last_of_burst (last_of_burst)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Width as the decoder applies it: 0 acts as 1, large values saturate
    function automatic int unsigned active_width();
        if (width_setting == 0)
            return 1;
        if (width_setting > DEF_MAX_ROW_PIXELS)
            return DEF_MAX_ROW_PIXELS;
        return width_setting;
    endfunction

    // Put one pixel into the current group; returns 1 when the row closes
    function automatic bit place_pixel(logic [3:0] pix);
        int unsigned bit_pos;
        int unsigned start_pos;
        bit          row_done;
        group_word_t grp;
        bit_pos = 7 - group_fill;
        for (int p = 0; p < 4; p++)
            if (pix[p])
                group_planes[p * 8 + bit_pos] = 1'b1;
        group_fill = group_fill + 1;
        start_pos  = row_pos;
        row_pos    = row_pos + 1;
        row_done   = (row_pos >= active_width());
        if (group_fill >= 8 || row_done)
        begin
            grp.group_index   = GROUP_INDEX_W'(start_pos >> 3);
            grp.plane_zero    = group_planes[7:0];
            grp.plane_one     = group_planes[15:8];
            grp.plane_two     = group_planes[23:16];
            grp.plane_three   = group_planes[31:24];
            grp.row_end       = row_done;
            grp.last_of_burst = 1'b0;
            expected_groups.push_back(grp);
            group_planes = '0;
            group_fill   = 0;
        end
        if (row_done)
        begin
            row_pos    = 0;
            prev_pixel = '0;
            dec_mode   = MODE_LITERAL;
            long_lo    = '0;
        end
        return row_done;
    endfunction

    // Repeat the previous pixel, clamped to what is left of the row
    function automatic bit run_pixels(int unsigned len);
        int unsigned w;
        int unsigned left;
        logic [3:0]  pix;
        w    = active_width();
        left = (row_pos < w) ? (w - row_pos) : 1;
        pix  = prev_pixel;
        if (len > left)
            len = left;
        dec_mode = MODE_LITERAL;
        for (int unsigned i = 0; i < len; i++)
            if (place_pixel(pix))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit decode_nibble(logic [3:0] nib);
        case (dec_mode)
            MODE_LITERAL:
            begin
                if (nib == prev_pixel)
                begin
                    dec_mode = MODE_COUNT;
                    return 1'b0;
                end
                prev_pixel = nib;
                return place_pixel(nib);
            end
            MODE_COUNT:
            begin
                if (nib == 0)
                begin
                    dec_mode = MODE_LONG_LO;
                    return 1'b0;
                end
                return run_pixels(nib);
            end
            MODE_LONG_LO:
            begin
                long_lo  = nib;
                dec_mode = MODE_LONG_HI;
                return 1'b0;
            end
            default:
                return run_pixels({nib, long_lo} + LONG_RUN_BIAS);
        endcase
    endfunction

    // Low nibble first; a row end drops the high nibble
    function automatic void decode_byte(logic [7:0] code_word);
        int unsigned n_before;
        n_before = expected_groups.size();
        if (!decode_nibble(code_word[3:0]))
            void'(decode_nibble(code_word[7:4]));
        if (expected_groups.size() > n_before)
            expected_groups[expected_groups.size() - 1].last_of_burst = 1'b1;
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    // Random words built from literal, short-run and long-run tokens plus stray nibbles
    function automatic void add_random_bytes(int unsigned count);
        int unsigned r;
        logic [3:0]  nib;
        while (gen_nibbles.size() < 2 * count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                nib = 4'($urandom_range(0, 15));
                if (nib == guess_pixel)
                    nib = nib + 4'd1;
                gen_nibbles.push_back(nib);
                guess_pixel = nib;
            end
            else if (r < 70)
            begin
                gen_nibbles.push_back(guess_pixel);
                gen_nibbles.push_back(4'($urandom_range(1, 15)));
            end
            else if (r < 85)
            begin
                gen_nibbles.push_back(guess_pixel);
                gen_nibbles.push_back(4'd0);
                gen_nibbles.push_back(4'($urandom_range(0, 15)));
                if ($urandom_range(0, 3) == 0)
                    gen_nibbles.push_back(4'($urandom_range(0, 15)));
                else
                    gen_nibbles.push_back(4'($urandom_range(0, 1)));
            end
            else
                gen_nibbles.push_back(4'($urandom_range(0, 15)));
        end
        repeat (count)
        begin
            nib = gen_nibbles.pop_front();
            pending_bytes.push_back({gen_nibbles.pop_front(), nib});
        end
    endfunction

    // Block is idle once every word is sent and every group has come back
    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || in_valid || expected_groups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [ROW_WIDTH_W-1:0] w);
        wait_for_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        row_width <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        width_setting = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input acceptance feeds the model
    always @(posedge clk)
    begin : byte_accept
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(code_byte);
            byte_taken = 1'b1;
            bytes_taken++;
        end
    end

    // Sender: bursts of words with random gaps, payload held while stalled
    always @(negedge clk)
    begin : byte_driver
        logic offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !byte_taken)
                offer = 1'b1;
            else
            begin
                byte_taken = 1'b0;
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
                if (burst_left > 0 && pending_bytes.size() > 0)
                begin
                    offer = 1'b1;
                    code_byte <= pending_bytes.pop_front();
                    burst_left--;
                end
                else if (burst_left == 0 && gap_left > 0)
                    gap_left--;
            end
        end
        in_valid <= offer;
    end

    // Receiver: segments of no/light/heavy stall, plus one long hold-off
    always @(negedge clk)
    begin : group_sink
        logic stall_next;
        stall_next = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                stall_next = 1'b1;
                hold_left--;
            end
            else if (!hold_done && bytes_taken >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                stall_next = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    sink_mode = $urandom_range(0, 2);
                    seg_left  = $urandom_range(5, 60);
                end
                seg_left--;
                case (sink_mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = ($urandom_range(0, 3) == 0);
                    default: stall_next = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
        out_stall <= stall_next;
    end

    // Output check against the oldest expected group
    always @(posedge clk)
    begin : group_monitor
        group_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_groups.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected group, expected none, actual index %0d",
                         $time, group_index);
            end
            else
            begin
                want = expected_groups.pop_front();
                check_field("group_index", want.group_index, group_index);
                check_field("plane_zero", want.plane_zero, plane_zero);
                check_field("plane_one", want.plane_one, plane_one);
                check_field("plane_two", want.plane_two, plane_two);
                check_field("plane_three", want.plane_three, plane_three);
                check_field("row_end", want.row_end, row_end);
                check_field("last_of_burst", want.last_of_burst, last_of_burst);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Main sequence: reset, then phases of row widths
    initial
    begin
        // reset width 640: all literals, short and long runs, the longest run
        pending_bytes = '{8'h00, 8'h00, 8'h21, 8'h43, 8'h65, 8'h87, 8'hA9,
                          8'hCB, 8'hED, 8'h35, 8'h03, 8'hFF, 8'hF0};
        add_random_bytes(30);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-pixel rows: every pixel ends the row and drops the high nibble
        write_row_width(ROW_WIDTH_W'(1));
        pending_bytes = '{8'h21, 8'h00, 8'h00, 8'h31};
        add_random_bytes(10);

        // zero width acts as one
        write_row_width(ROW_WIDTH_W'(0));
        add_random_bytes(8);

        // short run and long run clamped at row end
        write_row_width(ROW_WIDTH_W'(9));
        pending_bytes = '{8'h11, 8'h0F, 8'h22, 8'h30, 8'h01};
        add_random_bytes(25);

        // width above the maximum saturates
        write_row_width(ROW_WIDTH_W'(1023));
        add_random_bytes(40);

        // width lowered below the current row position
        write_row_width(ROW_WIDTH_W'(5));
        add_random_bytes(20);

        write_row_width(ROW_WIDTH_W'(8));
        add_random_bytes(20);

        write_row_width(ROW_WIDTH_W'(640));
        add_random_bytes(45);

        write_row_width(ROW_WIDTH_W'(17));
        add_random_bytes(30);

        wait_for_drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
